@@ design/trilinear_vector_interpolator_assert.svh @@
// Assertion macros for the trilinear vector interpolator.
// Define NO_ASSERTIONS to compile them out.
`ifndef TRILINEAR_VECTOR_INTERPOLATOR_ASSERT_SVH
`define TRILINEAR_VECTOR_INTERPOLATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define TVI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define TVI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define TVI_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TVI_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ design/tvi_pkg.sv @@
package tvi_pkg;

    localparam int FRAC_BITS       = 8;
    localparam int SAMPLE_BITS     = 16;
    localparam int POS_BITS        = 13;
    localparam int CELL_BITS       = POS_BITS - FRAC_BITS;
    localparam int RES_BITS        = 6;
    localparam int ADDR_IN_BITS    = 15;
    localparam int OUT_BITS        = 24;
    localparam int VERTICES_DEFAULT = 32768;

    // cz * res_x * res_y + cy * res_x + cx, plus the corner offsets
    localparam int ADDR_CALC_BITS  = 2 * RES_BITS + CELL_BITS + 1;

    // Per-axis weight, product of three weights, weighted sample, sum of eight
    localparam int AXW_BITS        = FRAC_BITS + 1;
    localparam int WGT_BITS        = 3 * FRAC_BITS + 1;
    localparam int PROD_BITS       = SAMPLE_BITS + WGT_BITS;
    localparam int ACC_BITS        = PROD_BITS + 3;

    localparam int CFG_IDX_BITS    = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RES_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RES_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RES_Z = 2'd2;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic                          req_type;
        logic [ADDR_IN_BITS-1:0]       vertex_addr;
        logic signed [SAMPLE_BITS-1:0] vec_x;
        logic signed [SAMPLE_BITS-1:0] vec_y;
        logic signed [SAMPLE_BITS-1:0] vec_z;
        logic [POS_BITS-1:0]           pos_x;
        logic [POS_BITS-1:0]           pos_y;
        logic [POS_BITS-1:0]           pos_z;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] out_x;
        logic signed [OUT_BITS-1:0] out_y;
        logic signed [OUT_BITS-1:0] out_z;
        logic                       out_of_range;
    } t_out_item;

endpackage

@@ design/tvi_ram.sv @@
module tvi_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/trilinear_vector_interpolator.sv @@
// Trilinear vector interpolator. Holds a 3D grid of signed 16-bit vectors in one
// single-port RAM of MAX_VERTICES entries (a power of two; addresses wrap). A write
// transfer stores one vertex. A query transfer gives a position
// with 5 integer and 8 fraction bits per axis; the eight cell corners are read one
// per cycle from the RAM and pushed through a three-stage weight/multiply pipeline,
// so the input is stalled until the result is loaded. Reads are skipped when the
// cell lies at or beyond the last vertex on any axis (result zero, out_of_range
// set). The finished result waits in an output register, so the next transfer is
// taken while it is stalled. Results are rounded to nearest (ties up) with 8
// fraction bits. Reading a vertex that was never written returns undefined data.
// The user must write res_x/res_y/res_z only while the block is idle (not enforced).
`include "trilinear_vector_interpolator_assert.svh"

module trilinear_vector_interpolator #(
    parameter int MAX_VERTICES = tvi_pkg::VERTICES_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  tvi_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output tvi_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_we,
    input  logic [tvi_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [tvi_pkg::RES_BITS-1:0]      i_cfg_wdata
);

    import tvi_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = (AW > ADDR_CALC_BITS) ? AW : ADDR_CALC_BITS;
    localparam int WW = (AW > ADDR_IN_BITS) ? AW : ADDR_IN_BITS;
    localparam int MW = 3 * SAMPLE_BITS;
    localparam int SH = 2 * FRAC_BITS;
    localparam int RW = ACC_BITS - SH;

    localparam logic [AXW_BITS-1:0]       AXIS_ONE = AXW_BITS'(64'd1 << FRAC_BITS);
    localparam logic signed [ACC_BITS-1:0] RND_C   = ACC_BITS'(64'd1 << (SH - 1));
    localparam logic signed [RW-1:0]       SAT_MAX = RW'((64'd1 << (OUT_BITS - 1)) - 64'd1);
    localparam logic signed [RW-1:0]       SAT_MIN = ~SAT_MAX;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_BASE,
        S_READ,
        S_DRAIN,
        S_ROUND,
        S_DONE
    } t_state;

    function automatic logic [AXW_BITS-1:0] axis_wgt(input logic hi,
                                                     input logic [FRAC_BITS-1:0] f);
        return hi ? {1'b0, f} : (AXIS_ONE - {1'b0, f});
    endfunction

    t_state r_state, n_state;

    logic [RES_BITS-1:0]     r_res_x, r_res_y, r_res_z;
    logic [CELL_BITS-1:0]    r_cx, r_cy, r_cz;
    logic [FRAC_BITS-1:0]    r_fx, r_fy, r_fz;
    logic [2*RES_BITS-1:0]   r_rxy, r_row;
    logic [CW-1:0]           r_base;
    logic [2:0]              r_idx;

    logic                    r_v1, r_v2, r_v3;
    logic                    r_hz1;
    logic [2*AXW_BITS-1:0]   r_wxy;
    logic [WGT_BITS-1:0]     r_w;
    logic [MW-1:0]           r_smp;
    logic signed [PROD_BITS-1:0] r_prod [3];
    logic signed [ACC_BITS-1:0]  r_acc [3];

    logic signed [OUT_BITS-1:0]  r_fin [3];
    logic                        r_fin_oor;
    logic                        r_out_valid;
    t_out_item                   r_out;

    logic                    w_in_accept;
    logic                    w_out_free;
    logic                    w_oor;
    logic                    w_hx, w_hy, w_hz;
    logic [CW-1:0]           w_rd_full;
    logic [WW-1:0]           w_wr_full;
    logic                    ram_en, ram_we;
    logic [AW-1:0]           ram_addr;
    logic [MW-1:0]           ram_wdata, ram_rdata;
    logic signed [ACC_BITS-1:0] w_sum [3];
    logic signed [ACC_BITS-1:0] w_shr [3];
    logic signed [RW-1:0]       w_rnd [3];
    logic signed [OUT_BITS-1:0] w_sat [3];

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign w_oor = ((RES_BITS'(r_cx) + RES_BITS'(1)) >= r_res_x) ||
                   ((RES_BITS'(r_cy) + RES_BITS'(1)) >= r_res_y) ||
                   ((RES_BITS'(r_cz) + RES_BITS'(1)) >= r_res_z);

    // Corner order walks the bottom face, then the top face.
    assign w_hx = r_idx[0] ^ r_idx[1];
    assign w_hy = r_idx[1];
    assign w_hz = r_idx[2];

    assign w_rd_full = r_base + CW'(w_hx)
                     + (w_hy ? CW'(r_res_x) : CW'(0))
                     + (w_hz ? CW'(r_rxy) : CW'(0));
    assign w_wr_full = WW'(i_in_data.vertex_addr);

    assign ram_we    = w_in_accept && (i_in_data.req_type == REQ_WRITE);
    assign ram_en    = ram_we || (r_state == S_READ);
    assign ram_addr  = ram_we ? w_wr_full[AW-1:0] : w_rd_full[AW-1:0];
    assign ram_wdata = {i_in_data.vec_z[SAMPLE_BITS-1:0],
                        i_in_data.vec_y[SAMPLE_BITS-1:0],
                        i_in_data.vec_x[SAMPLE_BITS-1:0]};

    tvi_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Round to nearest at FRAC_BITS fraction bits, then saturate.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sum[k] = r_acc[k] + RND_C;
            w_shr[k] = w_sum[k] >>> SH;
            w_rnd[k] = w_shr[k][RW-1:0];
            if (w_rnd[k] > SAT_MAX) begin
                w_sat[k] = SAT_MAX[OUT_BITS-1:0];
            end else if (w_rnd[k] < SAT_MIN) begin
                w_sat[k] = SAT_MIN[OUT_BITS-1:0];
            end else begin
                w_sat[k] = w_rnd[k][OUT_BITS-1:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept && (i_in_data.req_type == REQ_QUERY)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: n_state = w_oor ? S_DONE : S_BASE;
            S_BASE:  n_state = S_READ;
            S_READ: begin
                if (r_idx == 3'd7) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2 && !r_v3) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_x     <= RES_BITS'(32);
            r_res_y     <= RES_BITS'(32);
            r_res_z     <= RES_BITS'(32);
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RES_X: r_res_x <= i_cfg_wdata;
                    CFG_RES_Y: r_res_y <= i_cfg_wdata;
                    CFG_RES_Z: r_res_z <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (w_in_accept) begin
                r_cx <= i_in_data.pos_x[POS_BITS-1:FRAC_BITS];
                r_cy <= i_in_data.pos_y[POS_BITS-1:FRAC_BITS];
                r_cz <= i_in_data.pos_z[POS_BITS-1:FRAC_BITS];
                r_fx <= i_in_data.pos_x[FRAC_BITS-1:0];
                r_fy <= i_in_data.pos_y[FRAC_BITS-1:0];
                r_fz <= i_in_data.pos_z[FRAC_BITS-1:0];
            end

            if (r_state == S_CHECK) begin
                r_rxy <= (2*RES_BITS)'(r_res_x) * (2*RES_BITS)'(r_res_y);
                r_row <= (2*RES_BITS)'(r_cy) * (2*RES_BITS)'(r_res_x)
                       + (2*RES_BITS)'(r_cx);
                for (int k = 0; k < 3; k++) begin
                    r_acc[k] <= '0;
                    r_fin[k] <= '0;
                end
                r_fin_oor <= w_oor;
            end

            if (r_state == S_BASE) begin
                r_base <= CW'(r_cz) * CW'(r_rxy) + CW'(r_row);
                r_idx  <= 3'd0;
            end

            // Stage 1: corner read issued, x*y weight formed.
            r_v1 <= (r_state == S_READ);
            if (r_state == S_READ) begin
                r_idx <= r_idx + 3'd1;
                r_hz1 <= w_hz;
                r_wxy <= (2*AXW_BITS)'(axis_wgt(w_hx, r_fx))
                       * (2*AXW_BITS)'(axis_wgt(w_hy, r_fy));
            end

            // Stage 2: RAM data lands, full weight formed.
            r_v2 <= r_v1;
            if (r_v1) begin
                r_smp <= ram_rdata;
                r_w   <= WGT_BITS'(r_wxy) * WGT_BITS'(axis_wgt(r_hz1, r_fz));
            end

            // Stage 3: weighted samples.
            r_v3 <= r_v2;
            if (r_v2) begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[k] <= PROD_BITS'($signed(r_smp[k*SAMPLE_BITS +: SAMPLE_BITS])
                                           * $signed({1'b0, r_w}));
                end
            end

            // Stage 4: accumulate.
            if (r_v3) begin
                for (int k = 0; k < 3; k++) begin
                    r_acc[k] <= r_acc[k] + ACC_BITS'(r_prod[k]);
                end
            end

            if (r_state == S_ROUND) begin
                for (int k = 0; k < 3; k++) begin
                    r_fin[k] <= w_sat[k];
                end
            end

            // Output register: drop on transfer, load when the query is done.
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid        <= 1'b1;
                r_out.out_x        <= r_fin[0];
                r_out.out_y        <= r_fin[1];
                r_out.out_z        <= r_fin[2];
                r_out.out_of_range <= r_fin_oor;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `TVI_ASSERT_IMPLY(a_load_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_DONE)
    `TVI_ASSERT_IMPLY(a_round_drained, i_clk, i_rst_n, r_state == S_ROUND, !r_v1 && !r_v2 && !r_v3)
    `TVI_ASSERT_NEXT(a_write_stays_idle, i_clk, i_rst_n, ram_we, r_state == S_IDLE)

endmodule
